@@ hdl/u2a_pkg.sv @@
// Shared types, constants and the code point map of the UTF-8 to ASCII transliterator.
package u2a_pkg;

  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned RUN_MAX     = 3;

  localparam logic [16:0] CAP_RESET = 17'd256;
  localparam logic [16:0] CAP_LIMIT = 17'd65536;

  // sequence kinds
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_TWO   = 2'd1;
  localparam logic [1:0] KIND_THREE = 2'd2;
  localparam logic [1:0] KIND_FOUR  = 2'd3;

  // source bytes
  localparam logic [7:0] BYTE_NUL   = 8'h00;
  localparam logic [7:0] BYTE_TAB   = 8'h09;
  localparam logic [7:0] BYTE_LF    = 8'h0A;
  localparam logic [7:0] BYTE_PRINT = 8'h20;

  // mapped code points
  localparam logic [15:0] CP_NBSP     = 16'h00A0;
  localparam logic [15:0] CP_MIDDOT   = 16'h00B7;
  localparam logic [15:0] CP_EN_DASH  = 16'h2013;
  localparam logic [15:0] CP_EM_DASH  = 16'h2014;
  localparam logic [15:0] CP_LSQUO    = 16'h2018;
  localparam logic [15:0] CP_RSQUO    = 16'h2019;
  localparam logic [15:0] CP_LDQUO    = 16'h201C;
  localparam logic [15:0] CP_RDQUO    = 16'h201D;
  localparam logic [15:0] CP_BULLET   = 16'h2022;
  localparam logic [15:0] CP_ELLIPSIS = 16'h2026;

  // output characters
  localparam logic [6:0] ASC_NUL   = 7'h00;
  localparam logic [6:0] ASC_SPACE = 7'h20;
  localparam logic [6:0] ASC_DQUOT = 7'h22;
  localparam logic [6:0] ASC_SQUOT = 7'h27;
  localparam logic [6:0] ASC_DASH  = 7'h2D;
  localparam logic [6:0] ASC_DOT   = 7'h2E;

  typedef struct packed {
    logic [6:0]  ch;
    logic [15:0] idx;
    logic        last;
    logic        str_end;
  } entry_t;

  // up to three characters caused by one byte; ent[0] goes out first
  typedef struct packed {
    logic [1:0]                 cnt;
    entry_t [RUN_MAX-1:0]       ent;
  } run_t;

  // replacement text before the capacity check
  typedef struct packed {
    logic [1:0]                 len;
    logic [RUN_MAX-1:0][6:0]    ch;
  } text_t;

  function automatic text_t map_code(input logic [1:0] kind, input logic [15:0] cp);
    text_t t;
    t = '0;
    if (kind == KIND_TWO) begin
      case (cp)
        CP_NBSP: begin
          t.len   = 2'd1;
          t.ch[0] = ASC_SPACE;
        end
        CP_MIDDOT: begin
          t.len   = 2'd1;
          t.ch[0] = ASC_DOT;
        end
        default: t = '0;
      endcase
    end else if (kind == KIND_THREE) begin
      case (cp)
        CP_EN_DASH, CP_EM_DASH: begin
          t.len   = 2'd3;
          t.ch[0] = ASC_SPACE;
          t.ch[1] = ASC_DASH;
          t.ch[2] = ASC_SPACE;
        end
        CP_LSQUO, CP_RSQUO: begin
          t.len   = 2'd1;
          t.ch[0] = ASC_SQUOT;
        end
        CP_LDQUO, CP_RDQUO: begin
          t.len   = 2'd1;
          t.ch[0] = ASC_DQUOT;
        end
        CP_ELLIPSIS: begin
          t.len   = 2'd3;
          t.ch[0] = ASC_DOT;
          t.ch[1] = ASC_DOT;
          t.ch[2] = ASC_DOT;
        end
        CP_BULLET: begin
          t.len   = 2'd1;
          t.ch[0] = ASC_DASH;
        end
        default: t = '0;
      endcase
    end
    return t;
  endfunction

endpackage

@@ hdl/u2a_if.sv @@
// Valid/ready channel interfaces for source bytes and ASCII result items.
interface u2a_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source(output valid, output in_byte, input ready);
  modport sink(input valid, input in_byte, output ready);
endinterface

interface u2a_char_if;
  logic        valid;
  logic        ready;
  logic [6:0]  out_char;
  logic [15:0] out_index;
  logic        last_of_run;
  logic        string_end;

  modport source(output valid, output out_char, output out_index, output last_of_run,
                 output string_end, input ready);
  modport sink(input valid, input out_char, input out_index, input last_of_run,
               input string_end, output ready);
endinterface

@@ hdl/utf8_to_ascii_transliterator.sv @@
// Top level of the UTF-8 to ASCII transliterator: input register, decoder, result queue.
//
// Usage:
//   utf8  - sink channel, one UTF-8 source byte per item; a zero byte ends the string.
//   ascii - source channel, one ASCII character per item with its destination index,
//           a last-of-run flag for the final character caused by one source byte,
//           and a string-end flag on the terminator.
//   cfg_we/cfg_wdata - writes the destination capacity (terminator included).
//           Write it only while the block is idle. Zero suppresses all output.
// Throughput: one byte per cycle while the queue has room. A byte is registered on
//   acceptance, decoded once the queue has room, and its run (zero to three
//   characters) is written into the result queue in that same cycle. The queue
//   drains one item per cycle while the receiver is ready.
// Path: each character passes the input register and the result queue.
// Stalls: the decoder advances only while the queue has room for a full run, so
//   utf8.ready drops when the receiver stalls and the queue fills up; no item is
//   lost or repeated.
// Reset: rst is synchronous; it empties the queue and input register, closes any
//   open sequence, zeroes the write position and sets capacity to 256.
module utf8_to_ascii_transliterator #(
  parameter int unsigned QDepth = u2a_pkg::QUEUE_DEPTH,
  localparam int unsigned LevelW = $clog2(QDepth + 1)
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [16:0]  cfg_wdata,
  u2a_byte_if.sink     utf8,
  u2a_char_if.source   ascii
);

  logic [16:0]       capacity;
  logic              in_vld;
  logic [7:0]        in_byte_r;
  logic              adv;
  logic              room;
  logic [LevelW-1:0] level;
  u2a_pkg::run_t     run;

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= u2a_pkg::CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  // input register; the byte moves into the decoder once the queue has room
  assign adv        = in_vld && room;
  assign utf8.ready = !in_vld || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (utf8.valid && utf8.ready) begin
      in_vld <= 1'b1;
    end else if (adv) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (utf8.valid && utf8.ready) begin
      in_byte_r <= utf8.in_byte;
    end
  end

  u2a_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .data_byte (in_byte_r),
    .capacity  (capacity),
    .run       (run)
  );

  u2a_outq #(
    .Depth (QDepth)
  ) u_outq (
    .clk     (clk),
    .rst     (rst),
    .push_en (adv),
    .run     (run),
    .room    (room),
    .level   (level),
    .ascii   (ascii)
  );

`ifndef ASSERT_OFF
  // only the terminator carries a zero character
  a_nul_is_end: assert property (@(posedge clk) disable iff (rst)
    ascii.valid |-> ((ascii.out_char == u2a_pkg::ASC_NUL) == ascii.string_end))
    else $error("zero character and string end disagree");

  // the terminator always closes its run
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    ascii.valid && ascii.string_end |-> ascii.last_of_run)
    else $error("terminator not marked last of run");

  // queue never holds more than its depth
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    level <= LevelW'(QDepth))
    else $error("result queue overflow");

  // input stalls only with a held byte waiting for queue room
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !utf8.ready |-> in_vld && !room)
    else $error("input stalled without cause");
`endif

endmodule

@@ hdl/u2a_decode.sv @@
// UTF-8 sequence decoder, string state, capacity limit; one byte per cycle on adv.
module u2a_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic [7:0]        data_byte,
  input  logic [16:0]       capacity,
  output u2a_pkg::run_t     run
);

  logic [1:0]  pend;
  logic [1:0]  kind;
  logic [15:0] cb;
  logic [15:0] wc;

  logic [1:0]  pend_next;
  logic [1:0]  kind_next;
  logic [15:0] cb_next;
  logic [15:0] wc_next;

  u2a_pkg::text_t txt;
  logic           term;
  logic           lead;
  logic [1:0]     pend_dec;
  logic [15:0]    cb_shift;
  logic [16:0]    cap_eff;
  logic [u2a_pkg::RUN_MAX-1:0] emit;
  logic [1:0]     n_emit;

  assign cap_eff  = (capacity > u2a_pkg::CAP_LIMIT) ? u2a_pkg::CAP_LIMIT : capacity;
  assign pend_dec = pend - 2'd1;
  assign cb_shift = {cb[9:0], data_byte[5:0]};

  // sequence tracking
  always_comb begin
    pend_next = pend;
    kind_next = kind;
    cb_next   = cb;
    txt       = '0;
    term      = 1'b0;
    lead      = 1'b1;
    if (pend != 2'd0) begin
      if (data_byte[7:6] == 2'b10) begin
        lead      = 1'b0;
        pend_next = pend_dec;
        if (kind != u2a_pkg::KIND_FOUR) begin
          cb_next = cb_shift;
        end
        if (pend_dec == 2'd0) begin
          txt       = u2a_pkg::map_code(kind, cb_next);
          kind_next = u2a_pkg::KIND_NONE;
          cb_next   = '0;
        end
      end else begin
        // continuation missing: drop the open sequence, take this byte as a lead
        pend_next = 2'd0;
        kind_next = u2a_pkg::KIND_NONE;
        cb_next   = '0;
      end
    end
    if (lead) begin
      if (data_byte == u2a_pkg::BYTE_NUL) begin
        term      = 1'b1;
        pend_next = 2'd0;
        kind_next = u2a_pkg::KIND_NONE;
        cb_next   = '0;
      end else if (!data_byte[7]) begin
        if (data_byte >= u2a_pkg::BYTE_PRINT || data_byte == u2a_pkg::BYTE_TAB ||
            data_byte == u2a_pkg::BYTE_LF) begin
          txt.len   = 2'd1;
          txt.ch[0] = data_byte[6:0];
        end
      end else if (data_byte[7:5] == 3'b110) begin
        kind_next = u2a_pkg::KIND_TWO;
        pend_next = 2'd1;
        cb_next   = {11'd0, data_byte[4:0]};
      end else if (data_byte[7:4] == 4'b1110) begin
        kind_next = u2a_pkg::KIND_THREE;
        pend_next = 2'd2;
        cb_next   = {12'd0, data_byte[3:0]};
      end else if (data_byte[7:3] == 5'b11110) begin
        kind_next = u2a_pkg::KIND_FOUR;
        pend_next = 2'd3;
        cb_next   = '0;
      end
      // stray continuations and 0xF8..0xFF fall through and are dropped
    end
  end

  // capacity cut: emitted characters always form a prefix of the text
  always_comb begin
    for (int i = 0; i < u2a_pkg::RUN_MAX; i++) begin
      emit[i] = (2'(i) < txt.len) && (({1'b0, wc} + 17'(i + 1)) < cap_eff);
    end
    n_emit = 2'(emit[0]) + 2'(emit[1]) + 2'(emit[2]);
    run    = '0;
    if (term) begin
      run.cnt            = (cap_eff != 17'd0) ? 2'd1 : 2'd0;
      run.ent[0].ch      = u2a_pkg::ASC_NUL;
      run.ent[0].idx     = wc;
      run.ent[0].last    = 1'b1;
      run.ent[0].str_end = 1'b1;
      wc_next            = '0;
    end else begin
      run.cnt = n_emit;
      for (int i = 0; i < u2a_pkg::RUN_MAX; i++) begin
        run.ent[i].ch      = txt.ch[i];
        run.ent[i].idx     = wc + 16'(i);
        run.ent[i].last    = (2'(i + 1) == n_emit);
        run.ent[i].str_end = 1'b0;
      end
      wc_next = wc + 16'(n_emit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 2'd0;
      kind <= u2a_pkg::KIND_NONE;
      cb   <= '0;
      wc   <= '0;
    end else if (adv) begin
      pend <= pend_next;
      kind <= kind_next;
      cb   <= cb_next;
      wc   <= wc_next;
    end
  end

endmodule

@@ hdl/u2a_outq.sv @@
// Result queue: a run of up to three items in per cycle, one out per ready cycle.
module u2a_outq #(
  parameter int unsigned Depth = u2a_pkg::QUEUE_DEPTH,
  localparam int unsigned PtrW = $clog2(Depth),
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_en,
  input  u2a_pkg::run_t     run,
  output logic              room,
  output logic [CntW-1:0]   level,
  u2a_char_if.source        ascii
);

  u2a_pkg::entry_t mem [Depth];

  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic [PtrW-1:0] wr_idx [u2a_pkg::RUN_MAX];
  logic [PtrW-1:0] wr_ptr_next;
  logic [PtrW-1:0] rd_ptr_next;
  logic [1:0]      push_cnt;
  logic            pop;
  logic [PtrW:0]   sum;

  function automatic logic [PtrW-1:0] wrap(input logic [PtrW:0] v);
    logic [PtrW:0] r;
    r = (v >= (PtrW + 1)'(Depth)) ? v - (PtrW + 1)'(Depth) : v;
    return r[PtrW-1:0];
  endfunction

  assign push_cnt = push_en ? run.cnt : 2'd0;
  assign pop      = ascii.valid && ascii.ready;

  always_comb begin
    for (int i = 0; i < u2a_pkg::RUN_MAX; i++) begin
      wr_idx[i] = wrap({1'b0, wr_ptr} + (PtrW + 1)'(i));
    end
    sum         = {1'b0, wr_ptr} + (PtrW + 1)'(push_cnt);
    wr_ptr_next = wrap(sum);
    rd_ptr_next = wrap({1'b0, rd_ptr} + (PtrW + 1)'(1));
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      for (int i = 0; i < u2a_pkg::RUN_MAX; i++) begin
        if (2'(i) < run.cnt) begin
          mem[wr_idx[i]] <= run.ent[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      if (pop) begin
        rd_ptr <= rd_ptr_next;
      end
      count <= count + CntW'(push_cnt) - CntW'(pop);
    end
  end

  assign room  = count <= CntW'(Depth - u2a_pkg::RUN_MAX);
  assign level = count;

  assign ascii.valid       = count != '0;
  assign ascii.out_char    = mem[rd_ptr].ch;
  assign ascii.out_index   = mem[rd_ptr].idx;
  assign ascii.last_of_run = mem[rd_ptr].last;
  assign ascii.string_end  = mem[rd_ptr].str_end;

endmodule

@@ verif/u2a_checker.sv @@
// Checker: predicts the ASCII items from the accepted source bytes and compares them.
module u2a_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata,
  u2a_byte_if         byte_ch,
  u2a_char_if         char_ch,
  output int          errors,
  output int          pending,
  output int          checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PrintMax = 40;

  logic [16:0]       dest_cap;
  logic [15:0]       dest_pos;
  logic [1:0]        open_left;
  logic [1:0]        seq_kind;
  logic [15:0]       cp_acc;
  u2a_pkg::entry_t   char_q[$];

  function automatic int spell(input logic [1:0] kind, input logic [15:0] cp,
                               output logic [2:0][6:0] txt);
    txt   = '0;
    spell = 0;
    if (kind == u2a_pkg::KIND_TWO) begin
      if (cp == u2a_pkg::CP_NBSP) begin
        txt[0] = u2a_pkg::ASC_SPACE;
        spell  = 1;
      end else if (cp == u2a_pkg::CP_MIDDOT) begin
        txt[0] = u2a_pkg::ASC_DOT;
        spell  = 1;
      end
    end else if (kind == u2a_pkg::KIND_THREE) begin
      case (cp)
        u2a_pkg::CP_EN_DASH, u2a_pkg::CP_EM_DASH: begin
          txt   = {u2a_pkg::ASC_SPACE, u2a_pkg::ASC_DASH, u2a_pkg::ASC_SPACE};
          spell = 3;
        end
        u2a_pkg::CP_LSQUO, u2a_pkg::CP_RSQUO: begin
          txt[0] = u2a_pkg::ASC_SQUOT;
          spell  = 1;
        end
        u2a_pkg::CP_LDQUO, u2a_pkg::CP_RDQUO: begin
          txt[0] = u2a_pkg::ASC_DQUOT;
          spell  = 1;
        end
        u2a_pkg::CP_ELLIPSIS: begin
          txt   = {u2a_pkg::ASC_DOT, u2a_pkg::ASC_DOT, u2a_pkg::ASC_DOT};
          spell = 3;
        end
        u2a_pkg::CP_BULLET: begin
          txt[0] = u2a_pkg::ASC_DASH;
          spell  = 1;
        end
        default: spell = 0;
      endcase
    end
  endfunction

  function automatic int room();
    room = (dest_cap > u2a_pkg::CAP_LIMIT) ? int'(u2a_pkg::CAP_LIMIT) : int'(dest_cap);
  endfunction

  // characters from index capacity - 1 on are dropped; last_of_run marks the last kept
  task automatic put_run(input logic [2:0][6:0] txt, input int n);
    u2a_pkg::entry_t e;
    int              kept;
    kept = 0;
    for (int k = 0; k < n; k++) begin
      if (int'(dest_pos) + 1 < room()) begin
        e.ch      = txt[k];
        e.idx     = dest_pos;
        e.last    = 1'b0;
        e.str_end = 1'b0;
        char_q.push_back(e);
        dest_pos = dest_pos + 16'd1;
        kept++;
      end
    end
    if (kept > 0) char_q[char_q.size() - 1].last = 1'b1;
  endtask

  task automatic close_seq();
    open_left = 2'd0;
    seq_kind  = u2a_pkg::KIND_NONE;
    cp_acc    = '0;
  endtask

  task automatic take_byte(input logic [7:0] b);
    logic [2:0][6:0] txt;
    int              n;
    u2a_pkg::entry_t e;
    logic            consumed;
    consumed = 1'b0;
    if (open_left != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        consumed = 1'b1;
        if (seq_kind != u2a_pkg::KIND_FOUR) cp_acc = {cp_acc[9:0], b[5:0]};
        open_left = open_left - 2'd1;
        if (open_left == 2'd0) begin
          n = spell(seq_kind, cp_acc, txt);
          close_seq();
          put_run(txt, n);
        end
      end else begin
        // missing continuation: drop the open sequence, treat b as a lead byte
        close_seq();
      end
    end
    if (!consumed) begin
      if (b == u2a_pkg::BYTE_NUL) begin
        if (room() > 0) begin
          e.ch      = u2a_pkg::ASC_NUL;
          e.idx     = dest_pos;
          e.last    = 1'b1;
          e.str_end = 1'b1;
          char_q.push_back(e);
        end
        close_seq();
        dest_pos = '0;
      end else if (!b[7]) begin
        if (b >= u2a_pkg::BYTE_PRINT || b == u2a_pkg::BYTE_TAB || b == u2a_pkg::BYTE_LF) begin
          txt    = '0;
          txt[0] = b[6:0];
          put_run(txt, 1);
        end
      end else if (b[7:5] == 3'b110) begin
        seq_kind  = u2a_pkg::KIND_TWO;
        open_left = 2'd1;
        cp_acc    = {11'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        seq_kind  = u2a_pkg::KIND_THREE;
        open_left = 2'd2;
        cp_acc    = {12'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        seq_kind  = u2a_pkg::KIND_FOUR;
        open_left = 2'd3;
        cp_acc    = '0;
      end
      // stray continuations and 0xF8..0xFF fall through untouched
    end
  endtask

  task automatic report(input string what, input int got, input int want);
    errors++;
    if (errors <= PrintMax)
      $display("[%0t] mismatch: %s got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    u2a_pkg::entry_t want;
    if (rst) begin
      dest_cap = u2a_pkg::CAP_RESET;
      dest_pos = '0;
      close_seq();
      char_q.delete();
    end else begin
      if (char_ch.valid && char_ch.ready) begin
        checked++;
        if (char_q.size() == 0) begin
          report("item with nothing expected, out_char", int'(char_ch.out_char), 0);
        end else begin
          want = char_q.pop_front();
          if (char_ch.out_char !== want.ch)
            report("out_char", int'(char_ch.out_char), int'(want.ch));
          if (char_ch.out_index !== want.idx)
            report("out_index", int'(char_ch.out_index), int'(want.idx));
          if (char_ch.last_of_run !== want.last)
            report("last_of_run", int'(char_ch.last_of_run), int'(want.last));
          if (char_ch.string_end !== want.str_end)
            report("string_end", int'(char_ch.string_end), int'(want.str_end));
        end
      end
      if (byte_ch.valid && byte_ch.ready) take_byte(byte_ch.in_byte);
      if (cfg_we) dest_cap = cfg_wdata;
    end
    pending = char_q.size();
  end

endmodule

@@ verif/tb_utf8_to_ascii_transliterator.sv @@
// Testbench top: clock, reset, byte stimulus, result backpressure and the verdict.
module tb_utf8_to_ascii_transliterator;
  timeunit 1ns;
  timeprecision 1ps;

  // Extra wait once no character is outstanding, for when the last bytes of a
  // phase produce nothing.
  localparam int Settle   = 6;
  localparam int CycleMax = 200000;
  localparam int Budget   = 44;   // counted bytes per random phase
  localparam int NPhases  = 9;
  localparam int CalmPhase = 4;

  // Opening bytes: pass-through extremes, dropped controls, mapped two- and
  // three-byte points, stray continuation, dead lead bytes, a four-byte skip,
  // a missing continuation and the terminator.
  localparam logic [7:0] OPENING [25] = '{
    8'h41, 8'h7F, 8'h20, 8'h09, 8'h0A, 8'h01, 8'h1F,
    8'hC2, 8'hA0,                    // no-break space
    8'hE2, 8'h80, 8'h93,             // en dash
    8'hE2, 8'h80, 8'hA6,             // ellipsis
    8'h80,                           // stray continuation
    8'hFF, 8'hF8,                    // never lead bytes
    8'hF0, 8'h9F, 8'h98, 8'h80,      // four-byte, skipped
    8'hC3, 8'h41,                    // lead cut short, 'A' decoded again
    8'h00
  };

  localparam logic [15:0] MAPPED [10] = '{
    u2a_pkg::CP_NBSP, u2a_pkg::CP_MIDDOT, u2a_pkg::CP_EN_DASH, u2a_pkg::CP_EM_DASH,
    u2a_pkg::CP_LSQUO, u2a_pkg::CP_RSQUO, u2a_pkg::CP_LDQUO, u2a_pkg::CP_RDQUO,
    u2a_pkg::CP_BULLET, u2a_pkg::CP_ELLIPSIS
  };

  // capacity per random phase; the last one is drawn at run time
  localparam logic [16:0] CAPS [NPhases] = '{
    17'd0, 17'd1, 17'd2, 17'd3, 17'd65536, 17'h1FFFF, 17'd65537, 17'd6, 17'd0
  };

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [16:0] cfg_wdata;
  logic        calm;      // no idling on either side while set

  int          fails;
  int          pending;
  int          checked;
  int          sent;
  int          cycles;
  logic [7:0]  burst[$];

  u2a_byte_if byte_ch ();
  u2a_char_if char_ch ();

  utf8_to_ascii_transliterator uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .utf8      (byte_ch),
    .ascii     (char_ch)
  );

  u2a_checker chk (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .byte_ch   (byte_ch),
    .char_ch   (char_ch),
    .errors    (fails),
    .pending   (pending),
    .checked   (checked)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver: stalls about a quarter of the cycles outside calm stretches.
  always @(posedge clk) begin
    if (calm) char_ch.ready <= 1'b1;
    else char_ch.ready <= ($urandom_range(99) >= 26);
  end

  // Watchdog on total cycles.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleMax) begin
      $display("watchdog expired after %0d cycles, %0d characters outstanding",
               cycles, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offer one byte, with random idle cycles in front, and hold it until accepted.
  task automatic push_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < 26) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.in_byte <= b;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    sent++;
  endtask

  // Stop sending until every predicted character has come out, then let the
  // pipeline empty of bytes that produce nothing.
  task automatic drain();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (Settle) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [16:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [7:0] cont_byte();
    cont_byte = 8'($urandom_range(8'h80, 8'hBF));
  endfunction

  // Append one token of UTF-8 text (or noise) to burst. Returns how many of its
  // bytes count toward the phase budget; pure noise counts for nothing.
  function automatic int make_token();
    int          roll;
    int          need;
    logic [15:0] cp;
    roll = $urandom_range(99);
    make_token = 0;
    if (roll < 35) begin
      burst.push_back(8'($urandom_range(8'h20, 8'h7F)));
      make_token = 1;
    end else if (roll < 40) begin
      burst.push_back(($urandom_range(1) != 0) ? u2a_pkg::BYTE_TAB : u2a_pkg::BYTE_LF);
      make_token = 1;
    end else if (roll < 44) begin
      burst.push_back(8'($urandom_range(8'h01, 8'h1F)));
    end else if (roll < 60) begin
      cp = MAPPED[$urandom_range(9)];
      if (cp[15:11] == 5'd0) begin
        burst.push_back({3'b110, cp[10:6]});
        burst.push_back({2'b10, cp[5:0]});
        make_token = 2;
      end else begin
        burst.push_back({4'hE, cp[15:12]});
        burst.push_back({2'b10, cp[11:6]});
        burst.push_back({2'b10, cp[5:0]});
        make_token = 3;
      end
    end else if (roll < 67) begin
      burst.push_back(8'($urandom_range(8'hC0, 8'hDF)));
      burst.push_back(cont_byte());
      make_token = 2;
    end else if (roll < 74) begin
      burst.push_back(8'($urandom_range(8'hE0, 8'hEF)));
      burst.push_back(cont_byte());
      burst.push_back(cont_byte());
      make_token = 3;
    end else if (roll < 79) begin
      burst.push_back(8'($urandom_range(8'hF0, 8'hF7)));
      repeat (3) burst.push_back(cont_byte());
      make_token = 4;
    end else if (roll < 85) begin
      // sequence cut short; whatever comes next breaks it
      need = $urandom_range(1, 3);
      case (need)
        1: burst.push_back(8'($urandom_range(8'hC0, 8'hDF)));
        2: burst.push_back(8'($urandom_range(8'hE0, 8'hEF)));
        default: burst.push_back(8'($urandom_range(8'hF0, 8'hF7)));
      endcase
      repeat ($urandom_range(0, need - 1)) burst.push_back(cont_byte());
      make_token = 1;
    end else if (roll < 88) begin
      burst.push_back(cont_byte());
    end else if (roll < 91) begin
      burst.push_back(8'($urandom_range(8'hF8, 8'hFF)));
    end else begin
      burst.push_back(u2a_pkg::BYTE_NUL);
      make_token = 1;
    end
  endfunction

  initial begin
    int          counted;
    int          paused;
    logic [16:0] cap_v;

    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    calm            <= 1'b0;
    byte_ch.valid   <= 1'b0;
    byte_ch.in_byte <= '0;
    sent = 0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed bytes at the reset capacity.
    foreach (OPENING[i]) push_byte(OPENING[i]);
    drain();

    // Random text, one phase per capacity; each phase pauses once in the middle
    // until the block has caught up.
    for (int p = 0; p < NPhases; p++) begin
      cap_v = (p == NPhases - 1) ? 17'($urandom_range(4, 40)) : CAPS[p];
      set_capacity(cap_v);
      calm   <= (p == CalmPhase);
      counted = 0;
      paused  = 0;
      while (counted < Budget) begin
        counted += make_token();
        while (burst.size() != 0) push_byte(burst.pop_front());
        if (!paused && counted >= Budget / 2) begin
          paused = 1;
          drain();
        end
      end
      drain();
    end
    calm <= 1'b0;

    $display("Covered %0d source bytes across %0d capacity settings (0 to 0x1FFFF),",
             sent, NPhases + 1);
    $display("with %0d ASCII items compared against the prediction.", checked);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
